// File: src/rau_pkg.sv
`default_nettype none

package rau_pkg;

	// default operand width, output field widths
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int NUM_OUT_W         = 33;
	localparam int DEN_OUT_W         = 31;

	// operation codes on the cmd field
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// which product the shared multiplier forms this cycle
	typedef enum logic [1:0] {
		MUL_NUM0,
		MUL_NUM1,
		MUL_DEN
	} mul_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     comb;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     res_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic err;
		logic num_zero;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

`default_nettype wire

// File: src/rau_ctrl.sv
`default_nettype none

module rau_ctrl import rau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic out_ready,
	output logic      out_valid,
	output ctl_t      ctl,
	input  wire sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_GCD,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		ctl.mul_sel = MUL_NUM0;
		case (state_q)
			S_IDLE: begin
				ctl.load = in_valid;
			end
			S_MUL0: begin
				ctl.mul_en  = !sts.err;
				ctl.mul_sel = MUL_NUM0;
			end
			S_MUL1: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_NUM1;
			end
			S_MUL2: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_DEN;
			end
			S_COMB: begin
				ctl.comb = 1'b1;
			end
			S_GCD: begin
				if (!sts.num_zero) begin
					ctl.gcd_step = !sts.gcd_done;
					ctl.div_init = sts.gcd_done;
				end
			end
			S_DIV: begin
				ctl.div_step = !sts.div_done;
			end
			S_FIN: begin
				ctl.res_load = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// new result loads as the old one leaves, or into an empty slot
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_MUL0;
				end
				S_MUL0: begin
					state_q <= sts.err ? S_FIN : S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_COMB;
				S_COMB: state_q <= S_GCD;
				S_GCD: begin
					if (sts.num_zero)
						state_q <= S_FIN;
					else if (sts.gcd_done)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/rau_dp.sv
`default_nettype none

module rau_dp import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctl_t                     ctl,
	output sts_t                          sts,
	input  wire logic [1:0]               op_in,
	input  wire logic [OPERAND_WIDTH-1:0] a_num,
	input  wire logic [OPERAND_WIDTH-1:0] a_den,
	input  wire logic [OPERAND_WIDTH-1:0] b_num,
	input  wire logic [OPERAND_WIDTH-1:0] b_den,
	output logic [NUM_OUT_W-1:0]          res_num,
	output logic [DEN_OUT_W-1:0]          res_den,
	output logic                          res_status
);

	localparam int W   = OPERAND_WIDTH;
	localparam int PW  = 2 * W;
	localparam int SW  = 2 * W + 1;
	localparam int KW  = $clog2(SW + 1);
	localparam int NXW = (SW > NUM_OUT_W) ? SW : NUM_OUT_W;
	localparam int DXW = (SW > DEN_OUT_W) ? SW : DEN_OUT_W;

	// operands, sign/magnitude
	logic [1:0]   op_q;
	logic         err_q;
	logic         an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [W-1:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;

	// products
	logic          p0_neg_q, p1_neg_q, den_neg_q;
	logic [PW-1:0] p0_mag_q, p1_mag_q, den_mag_q;

	// combined numerator
	logic          num_neg_q;
	logic [SW-1:0] num_mag_q;

	// binary gcd
	logic [SW-1:0] u_q, v_q;
	logic [KW-1:0] k_q;

	// two division lanes sharing the divisor
	logic [SW-1:0] d_q, rn_q, qn_q, rd_q, qd_q;
	logic [KW-1:0] cnt_q;

	// output payload
	logic [NUM_OUT_W-1:0] res_num_q;
	logic [DEN_OUT_W-1:0] res_den_q;
	logic                 res_status_q;

	logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		mag_of = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	assign an_mag = mag_of(a_num);
	assign ad_mag = mag_of(a_den);
	assign bn_mag = mag_of(b_num);
	assign bd_mag = mag_of(b_den);

	// multiplier operand select
	logic          x_neg, y_neg, flip;
	logic [W-1:0]  x_mag, y_mag;
	logic [PW-1:0] prod;
	logic          prod_neg;

	always_comb begin
		flip = 1'b0;
		case (ctl.mul_sel)
			MUL_NUM1: begin
				x_neg = bn_neg_q; x_mag = bn_mag_q;
				y_neg = ad_neg_q; y_mag = ad_mag_q;
				flip  = (op_q == OP_SUB);
			end
			MUL_DEN: begin
				x_neg = ad_neg_q; x_mag = ad_mag_q;
				if (op_q == OP_DIV) begin
					y_neg = bn_neg_q; y_mag = bn_mag_q;
				end else begin
					y_neg = bd_neg_q; y_mag = bd_mag_q;
				end
			end
			default: begin
				x_neg = an_neg_q; x_mag = an_mag_q;
				if (op_q == OP_MUL) begin
					y_neg = bn_neg_q; y_mag = bn_mag_q;
				end else begin
					y_neg = bd_neg_q; y_mag = bd_mag_q;
				end
			end
		endcase
	end

	assign prod     = PW'(x_mag) * PW'(y_mag);
	assign prod_neg = (prod != '0) && ((x_neg ^ y_neg) ^ flip);

	// sign/magnitude sum of the two numerator products
	logic [SW-1:0] e0, e1, sum_mag;
	logic          sum_neg;

	assign e0 = SW'(p0_mag_q);
	assign e1 = SW'(p1_mag_q);

	always_comb begin
		if (op_q == OP_MUL || op_q == OP_DIV) begin
			sum_mag = e0;
			sum_neg = p0_neg_q;
		end else if (p0_neg_q == p1_neg_q) begin
			sum_mag = e0 + e1;
			sum_neg = p0_neg_q;
		end else if (e0 >= e1) begin
			sum_mag = e0 - e1;
			sum_neg = p0_neg_q;
		end else begin
			sum_mag = e1 - e0;
			sum_neg = p1_neg_q;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	// restoring division step, one quotient bit per lane
	logic [SW:0] tn, td;
	logic        gen, ged;

	assign tn  = {rn_q, qn_q[SW-1]};
	assign td  = {rd_q, qd_q[SW-1]};
	assign gen = (tn >= {1'b0, d_q});
	assign ged = (td >= {1'b0, d_q});

	// result formation
	logic [NXW-1:0] nx;
	logic [DXW-1:0] dx;

	always_comb begin
		nx = NXW'(qn_q);
		if (num_neg_q != den_neg_q)
			nx = ~nx + NXW'(1);
		dx = DXW'(qd_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q     <= op_in;
			err_q    <= (ad_mag == '0) || (bd_mag == '0) ||
			            (op_in == OP_DIV && bn_mag == '0);
			an_neg_q <= a_num[W-1]; an_mag_q <= an_mag;
			ad_neg_q <= a_den[W-1]; ad_mag_q <= ad_mag;
			bn_neg_q <= b_num[W-1]; bn_mag_q <= bn_mag;
			bd_neg_q <= b_den[W-1]; bd_mag_q <= bd_mag;
		end
		if (ctl.mul_en) begin
			case (ctl.mul_sel)
				MUL_NUM1: begin
					p1_mag_q <= prod; p1_neg_q <= prod_neg;
				end
				MUL_DEN: begin
					den_mag_q <= prod; den_neg_q <= prod_neg;
				end
				default: begin
					p0_mag_q <= prod; p0_neg_q <= prod_neg;
				end
			endcase
		end
		if (ctl.comb) begin
			num_mag_q <= sum_mag;
			num_neg_q <= sum_neg;
			u_q       <= sum_mag;
			v_q       <= SW'(den_mag_q);
		end else if (ctl.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
		if (ctl.div_init) begin
			d_q  <= (u_q | v_q) << k_q;
			rn_q <= '0;
			qn_q <= num_mag_q;
			rd_q <= '0;
			qd_q <= SW'(den_mag_q);
		end else if (ctl.div_step) begin
			rn_q <= gen ? SW'(tn - {1'b0, d_q}) : tn[SW-1:0];
			qn_q <= {qn_q[SW-2:0], gen};
			rd_q <= ged ? SW'(td - {1'b0, d_q}) : td[SW-1:0];
			qd_q <= {qd_q[SW-2:0], ged};
		end
		if (ctl.res_load) begin
			if (err_q || num_mag_q == '0) begin
				res_num_q <= '0;
				res_den_q <= DEN_OUT_W'(1);
			end else begin
				res_num_q <= nx[NUM_OUT_W-1:0];
				res_den_q <= dx[DEN_OUT_W-1:0];
			end
			res_status_q <= err_q;
		end
	end

	// counters: common power of two, division bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.comb)
				k_q <= '0;
			else if (ctl.gcd_step && !u_q[0] && !v_q[0])
				k_q <= k_q + KW'(1);
			if (ctl.div_init)
				cnt_q <= KW'(SW);
			else if (ctl.div_step)
				cnt_q <= cnt_q - KW'(1);
		end
	end

	assign sts.err      = err_q;
	assign sts.num_zero = (num_mag_q == '0);
	assign sts.gcd_done = (u_q == '0) || (v_q == '0);
	assign sts.div_done = (cnt_q == '0);

	assign res_num    = res_num_q;
	assign res_den    = res_den_q;
	assign res_status = res_status_q;

endmodule

`default_nettype wire

// File: src/rational_arithmetic_unit.sv
// Sequence: an accepted request runs the three products, the binary-GCD loop
//   (one subtract or shift per step) and the bit-serial quotient lanes;
//   error requests go straight to the result, zero-numerator requests skip the division.
// One request in flight: a new request is taken only after the last result has
//   been loaded into the result register.
// Reset: arst_n asynchronous, active low; clears the controller and output valid.
`default_nettype none

module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	localparam int IN_BITS  = 2 + 4 * OPERAND_WIDTH,
	localparam int IN_TW    = 8 * ((IN_BITS + 7) / 8),
	localparam int OUT_TW   = 8 * ((NUM_OUT_W + DEN_OUT_W + 7) / 8)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request side
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// fields from bit 0 up: cmd[2], a_num, a_den, b_num, b_den (OPERAND_WIDTH each)
	input  wire logic [IN_TW-1:0]  s_axis_tdata,
	// result side
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// fields from bit 0 up: res_num[33] (signed), res_den[31]
	output logic [OUT_TW-1:0]      m_axis_tdata,
	// fields: status[1] (1 = zero denominator / divide by zero, result 0/1)
	output logic                   m_axis_tuser
);

	localparam int W = OPERAND_WIDTH;

	ctl_t ctl;
	sts_t sts;

	logic [1:0]           cmd;
	logic [W-1:0]         a_num, a_den, b_num, b_den;
	logic [NUM_OUT_W-1:0] res_num;
	logic [DEN_OUT_W-1:0] res_den;
	logic                 status;

	// unpack request
	assign cmd   = s_axis_tdata[1:0];
	assign a_num = s_axis_tdata[2 + 0*W +: W];
	assign a_den = s_axis_tdata[2 + 1*W +: W];
	assign b_num = s_axis_tdata[2 + 2*W +: W];
	assign b_den = s_axis_tdata[2 + 3*W +: W];

	// Controller sequences: load operands, three products through one
	// multiplier, sign/magnitude combine, binary GCD, then two restoring
	// division lanes dividing numerator and denominator by the GCD.
	// The result register lets a new request in while a result waits.
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.ctl       (ctl),
		.sts       (sts)
	);

	rau_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.op_in      (cmd),
		.a_num      (a_num),
		.a_den      (a_den),
		.b_num      (b_num),
		.b_den      (b_den),
		.res_num    (res_num),
		.res_den    (res_den),
		.res_status (status)
	);

	// pack result, zero-filled to whole bytes
	assign m_axis_tdata = OUT_TW'({res_den, res_num});
	assign m_axis_tuser = status;

endmodule

`default_nettype wire

// File: src/rau_checker.sv
`default_nettype none

module rau_checker import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	parameter int OUT_TW        = 64
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [OUT_TW-1:0] m_axis_tdata,
	input wire logic              m_axis_tuser
);

	logic [NUM_OUT_W-1:0] r_num;
	logic [DEN_OUT_W-1:0] r_den;

	assign r_num = m_axis_tdata[NUM_OUT_W-1:0];
	assign r_den = m_axis_tdata[NUM_OUT_W +: DEN_OUT_W];

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while one is in flight");

	// error results read 0/1
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (r_num == '0) && (r_den == DEN_OUT_W'(1)))
		else $error("error result is not 0/1");

	// zero normalizes to 0/1
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (r_num == '0) |-> (r_den == DEN_OUT_W'(1)))
		else $error("zero result with denominator other than 1");

	// denominator never zero when the fields hold the full result
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (OPERAND_WIDTH <= 16) |-> (r_den != '0))
		else $error("zero denominator on result");

endmodule

bind rational_arithmetic_unit rau_checker #(
	.OPERAND_WIDTH (OPERAND_WIDTH),
	.OUT_TW        (OUT_TW)
) u_rau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
